// ===== sv/lav_pkg.sv =====
// lav_pkg: shared types and constants for the look-at view matrix block
// item layouts for both channels, row codes, saturation limits, unit latency
// no dependencies
package lav_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int MAG_BITS = 31;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ROW_SIDE  = 2'd0,
    ROW_UP    = 2'd1,
    ROW_FWD   = 2'd2,
    ROW_CONST = 2'd3
  } lav_row_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] upward_x;
    logic signed [31:0] upward_y;
    logic signed [31:0] upward_z;
  } lav_req_t;

  typedef struct packed {
    lav_row_t           row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               degenerate;
    logic               last_row;
  } lav_rsp_t;

  // register stages through one normalize unit
  function automatic int norm_lat(input int frac);
    return frac + 41;
  endfunction

endpackage

// ===== sv/lav_if.sv =====
// lav_req_if, lav_rsp_if: valid/ready channels of the look-at view matrix block
// payload types come from lav_pkg
interface lav_req_if;
  logic              valid;
  logic              ready;
  lav_pkg::lav_req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lav_rsp_if;
  logic              valid;
  logic              ready;
  lav_pkg::lav_rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/lav_norm.sv =====
// lav_norm: pipelined vector normalizer, one step of square root or division per stage
// magnitude prescale, sum of squares, digit-by-digit root, three restoring dividers
// depends on lav_pkg
module lav_norm #(
  parameter int IW = 33,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vin,
  input  logic [2:0][IW-1:0]          vec,
  output logic                        vout,
  output logic                        zero,
  output logic [2:0][FRAC_BITS+1:0]   nrm
);
  import lav_pkg::*;

  localparam int SW = $clog2(IW + 1);
  localparam int QB = FRAC_BITS + 1;
  localparam int NW = FRAC_BITS + 32;
  localparam int OW = FRAC_BITS + 2;
  localparam int SQW = 2 * MAG_BITS;

  logic                          v1, v2, v3, v4, v5;
  logic [2:0]                    sg1, sg2, sg3, sg4, sg5;
  logic [2:0][IW-1:0]            mg1_n, mg1, mg2, mg3;
  logic [IW-1:0]                 top_n, top2;
  logic                          z3, z4, z5;
  logic [SW-1:0]                 sh_n, sh3;
  logic [2:0][MAG_BITS-1:0]      m4_n, m4, m5;
  logic [2:0][SQW-1:0]           sq5;

  logic                          sv   [0:SQRT_STEPS];
  logic                          sz   [0:SQRT_STEPS];
  logic [2:0]                    ssg  [0:SQRT_STEPS];
  logic [2:0][MAG_BITS-1:0]      sm   [0:SQRT_STEPS];
  logic [63:0]                   sx   [0:SQRT_STEPS];
  logic [32:0]                   srem [0:SQRT_STEPS];
  logic [31:0]                   sroot[0:SQRT_STEPS];
  logic [63:0]                   sx_n   [1:SQRT_STEPS];
  logic [32:0]                   srem_n [1:SQRT_STEPS];
  logic [31:0]                   sroot_n[1:SQRT_STEPS];

  logic                          dv   [0:QB];
  logic                          dz   [0:QB];
  logic [2:0]                    dsg  [0:QB];
  logic [31:0]                   dlen [0:QB];
  logic [2:0][NW-1:0]            dn   [0:QB];
  logic [2:0][31:0]              drem [0:QB];
  logic [2:0][QB-1:0]            dq   [0:QB];
  logic [2:0][NW-1:0]            dn0_n;
  logic [2:0][31:0]              drem_n [0:QB];
  logic [2:0][QB-1:0]            dq_n   [1:QB];
  logic [2:0][OW-1:0]            nrm_n;

  // magnitude, maximum, leading one, prescale
  always_comb begin
    logic [IW+MAG_BITS-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      mg1_n[i] = vec[i][IW-1] ? (~vec[i] + 1'b1) : vec[i];
    end
    top_n = mg1[0];
    if (mg1[1] > top_n) top_n = mg1[1];
    if (mg1[2] > top_n) top_n = mg1[2];
    sh_n = '0;
    for (int b = 0; b < IW; b++) begin
      if (top2[b]) sh_n = SW'(b + 1);
    end
    for (int i = 0; i < 3; i++) begin
      ext = {mg3[i], MAG_BITS'(0)} >> sh3;
      m4_n[i] = ext[MAG_BITS-1:0];
    end
  end

  // square root, one result bit per stage
  always_comb begin
    logic [34:0] trial;
    logic [34:0] tsub;
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      trial = {srem[k-1], sx[k-1][63:62]};
      tsub = {1'b0, sroot[k-1], 2'b01};
      if (trial >= tsub) begin
        srem_n[k] = 33'(trial - tsub);
        sroot_n[k] = {sroot[k-1][30:0], 1'b1};
      end else begin
        srem_n[k] = trial[32:0];
        sroot_n[k] = {sroot[k-1][30:0], 1'b0};
      end
      sx_n[k] = {sx[k-1][61:0], 2'b00};
    end
  end

  // numerator with half divisor, then one quotient bit per stage
  always_comb begin
    logic [32:0] r;
    for (int i = 0; i < 3; i++) begin
      dn0_n[i] = NW'({sm[SQRT_STEPS][i], FRAC_BITS'(0)}) + NW'(sroot[SQRT_STEPS] >> 1);
      drem_n[0][i] = 32'(dn0_n[i] >> QB);
    end
    for (int j = 1; j <= QB; j++) begin
      for (int i = 0; i < 3; i++) begin
        r = {drem[j-1][i], dn[j-1][i][QB-j]};
        if (r >= {1'b0, dlen[j-1]}) begin
          drem_n[j][i] = 32'(r - {1'b0, dlen[j-1]});
          dq_n[j][i] = {dq[j-1][i][QB-2:0], 1'b1};
        end else begin
          drem_n[j][i] = r[31:0];
          dq_n[j][i] = {dq[j-1][i][QB-2:0], 1'b0};
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (dz[QB]) begin
        nrm_n[i] = '0;
      end else if (dsg[QB][i]) begin
        nrm_n[i] = ~OW'(dq[QB][i]) + 1'b1;
      end else begin
        nrm_n[i] = OW'(dq[QB][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int k = 0; k <= SQRT_STEPS; k++) sv[k] <= 1'b0;
      for (int j = 0; j <= QB; j++) dv[j] <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1 <= vin;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      sv[0] <= v5;
      for (int k = 1; k <= SQRT_STEPS; k++) sv[k] <= sv[k-1];
      dv[0] <= sv[SQRT_STEPS];
      for (int j = 1; j <= QB; j++) dv[j] <= dv[j-1];
      vout <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sg1[i] <= vec[i][IW-1];
      mg1 <= mg1_n;
      sg2 <= sg1;
      mg2 <= mg1;
      top2 <= top_n;
      sg3 <= sg2;
      mg3 <= mg2;
      z3 <= (top2 == '0);
      sh3 <= sh_n;
      sg4 <= sg3;
      z4 <= z3;
      m4 <= m4_n;
      sg5 <= sg4;
      z5 <= z4;
      m5 <= m4;
      for (int i = 0; i < 3; i++) sq5[i] <= SQW'(m4[i]) * SQW'(m4[i]);
      sz[0] <= z5;
      ssg[0] <= sg5;
      sm[0] <= m5;
      sx[0] <= 64'(sq5[0]) + 64'(sq5[1]) + 64'(sq5[2]);
      srem[0] <= '0;
      sroot[0] <= '0;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        sz[k] <= sz[k-1];
        ssg[k] <= ssg[k-1];
        sm[k] <= sm[k-1];
        sx[k] <= sx_n[k];
        srem[k] <= srem_n[k];
        sroot[k] <= sroot_n[k];
      end
      dz[0] <= sz[SQRT_STEPS];
      dsg[0] <= ssg[SQRT_STEPS];
      dlen[0] <= sroot[SQRT_STEPS];
      dn[0] <= dn0_n;
      drem[0] <= drem_n[0];
      dq[0] <= '0;
      for (int j = 1; j <= QB; j++) begin
        dz[j] <= dz[j-1];
        dsg[j] <= dsg[j-1];
        dlen[j] <= dlen[j-1];
        dn[j] <= dn[j-1];
        drem[j] <= drem_n[j];
        dq[j] <= dq_n[j];
      end
      zero <= dz[QB];
      nrm <= nrm_n;
    end
  end

endmodule

// ===== sv/look_at_view_matrix.sv =====
// Look-at view matrix builder for signed fixed-point eye, target and up vectors.
// An item enters only while the output register is empty or its last row is
// being taken; each item leaves as four rows (side, up, negated forward,
// constant) through a single output register, so that register sets the
// sustained rate. From acceptance to the first row an item passes through two
// normalize units in series (forward and up hint in parallel, then side),
// each 32 square-root stages and FRAC_BITS+1 divide stages long, plus the
// cross, dot and rounding stages. A stall on the result side holds the whole
// pipeline. Items with a zero-length vector give zero side, up and forward
// rows and the degenerate flag; translation entries saturate to 32 bits.
// depends on lav_pkg, lav_if, lav_norm
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  lav_req_if.sink     req,
  lav_rsp_if.source   rsp
);
  import lav_pkg::*;

  localparam int LAT = norm_lat(FRAC_BITS);
  localparam int VW = FRAC_BITS + 2;
  localparam int PW = 2 * VW;
  localparam int CW = PW + 1;
  localparam int UW = FRAC_BITS + 3;
  localparam int DPW = UW + 32;
  localparam int DSW = DPW + 2;
  localparam int RW = DSW + 1 - FRAC_BITS;
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic adv, take;

  logic               p_v;
  logic [2:0][31:0]   p_eye, p_tgt, p_up;
  logic [2:0][32:0]   dvec;

  logic               va, vb, vc, za, zb, zc;
  logic [2:0][VW-1:0] na, nb, nc;
  logic [2:0][31:0]   e_d [1:LAT];

  logic                 x1_v, x1_dg, x2_v, x2_dg;
  logic signed [PW-1:0] x1_p [6];
  logic [2:0][VW-1:0]   x1_f, x2_f;
  logic [2:0][31:0]     x1_e, x2_e;
  logic [2:0][CW-1:0]   x2_c;

  logic [2:0][VW-1:0] c_f  [1:LAT];
  logic [2:0][31:0]   c_e  [1:LAT];
  logic               c_dg [1:LAT];

  logic                  t_v  [1:6];
  logic                  t_dg [1:6];
  logic [2:0][VW-1:0]    t_s  [1:6];
  logic [2:0][VW-1:0]    t_f  [1:6];
  logic [2:0][31:0]      t_e  [1:3];
  logic [2:0][UW-1:0]    t_u  [3:6];
  logic signed [PW-1:0]  t1_p [6];
  logic [2:0][CW-1:0]    t2_d;
  logic [2:0][UW-1:0]    u_n;
  logic signed [DPW-1:0] t4_p [3][3];
  logic signed [DSW-1:0] t5_sum [3];
  logic [2:0]            t6_sg, sg_n;
  logic [RW-1:0]         t6_r [3];
  logic [RW-1:0]         r_n [3];
  logic [2:0][31:0]      col3_n;

  logic               ob_v, ob_dg;
  lav_row_t           ob_row;
  logic [2:0][VW-1:0] ob_s, ob_f;
  logic [2:0][UW-1:0] ob_u;
  logic [2:0][31:0]   ob_t;
  logic [3:0][31:0]   col;

  assign take = ob_v & rsp.ready;
  assign adv = !ob_v || (take && ob_row == ROW_CONST);
  assign req.ready = adv && !rst;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvec[i] = 33'($signed(p_tgt[i])) - 33'($signed(p_eye[i]));
    end
  end

  lav_norm #(.IW(33), .FRAC_BITS(FRAC_BITS)) u_norm_fwd (
    .clk(clk), .rst(rst), .en(adv), .vin(p_v), .vec(dvec),
    .vout(va), .zero(za), .nrm(na)
  );

  lav_norm #(.IW(32), .FRAC_BITS(FRAC_BITS)) u_norm_up (
    .clk(clk), .rst(rst), .en(adv), .vin(p_v), .vec(p_up),
    .vout(vb), .zero(zb), .nrm(nb)
  );

  lav_norm #(.IW(CW), .FRAC_BITS(FRAC_BITS)) u_norm_side (
    .clk(clk), .rst(rst), .en(adv), .vin(x2_v), .vec(x2_c),
    .vout(vc), .zero(zc), .nrm(nc)
  );

  // true up rounding, translation magnitudes and signs, translation saturation
  always_comb begin
    logic [CW-1:0]  um;
    logic [CW:0]    ur;
    logic [DSW-1:0] dm;
    logic [DSW:0]   dr;
    for (int i = 0; i < 3; i++) begin
      um = t2_d[i][CW-1] ? (~t2_d[i] + 1'b1) : t2_d[i];
      ur = {1'b0, um} + ((CW + 1)'(1) << (FRAC_BITS - 1));
      u_n[i] = t2_d[i][CW-1] ? UW'(~ur[CW:FRAC_BITS] + 1'b1) : UW'(ur[CW:FRAC_BITS]);
    end
    for (int r = 0; r < 3; r++) begin
      dm = t5_sum[r][DSW-1] ? DSW'(-t5_sum[r]) : DSW'(t5_sum[r]);
      dr = {1'b0, dm} + ((DSW + 1)'(1) << (FRAC_BITS - 1));
      r_n[r] = dr[DSW:FRAC_BITS];
      sg_n[r] = (r == 2) ? t5_sum[r][DSW-1] : !t5_sum[r][DSW-1];
    end
    for (int r = 0; r < 3; r++) begin
      if (!t6_sg[r]) begin
        col3_n[r] = (t6_r[r] > RW'(SAT_MAX)) ? SAT_MAX : t6_r[r][31:0];
      end else begin
        col3_n[r] = (t6_r[r] > RW'(SAT_MIN)) ? SAT_MIN : (~t6_r[r][31:0] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
      x1_v <= 1'b0;
      x2_v <= 1'b0;
      for (int k = 1; k <= 6; k++) t_v[k] <= 1'b0;
      ob_v <= 1'b0;
      ob_row <= ROW_SIDE;
    end else begin
      if (adv) begin
        p_v <= req.valid;
        x1_v <= va;
        x2_v <= x1_v;
        t_v[1] <= vc;
        for (int k = 2; k <= 6; k++) t_v[k] <= t_v[k-1];
        ob_v <= t_v[6];
        ob_row <= ROW_SIDE;
      end else if (take) begin
        ob_row <= lav_row_t'(ob_row + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_eye <= {req.data.eye_z, req.data.eye_y, req.data.eye_x};
      p_tgt <= {req.data.target_z, req.data.target_y, req.data.target_x};
      p_up <= {req.data.upward_z, req.data.upward_y, req.data.upward_x};

      e_d[1] <= p_eye;
      for (int k = 2; k <= LAT; k++) e_d[k] <= e_d[k-1];

      x1_p[0] <= PW'($signed(na[1])) * PW'($signed(nb[2]));
      x1_p[1] <= PW'($signed(na[2])) * PW'($signed(nb[1]));
      x1_p[2] <= PW'($signed(na[2])) * PW'($signed(nb[0]));
      x1_p[3] <= PW'($signed(na[0])) * PW'($signed(nb[2]));
      x1_p[4] <= PW'($signed(na[0])) * PW'($signed(nb[1]));
      x1_p[5] <= PW'($signed(na[1])) * PW'($signed(nb[0]));
      x1_f <= na;
      x1_e <= e_d[LAT];
      x1_dg <= za | zb;

      for (int i = 0; i < 3; i++) begin
        x2_c[i] <= CW'(x1_p[2*i]) - CW'(x1_p[2*i+1]);
      end
      x2_f <= x1_f;
      x2_e <= x1_e;
      x2_dg <= x1_dg;

      c_f[1] <= x2_f;
      c_e[1] <= x2_e;
      c_dg[1] <= x2_dg;
      for (int k = 2; k <= LAT; k++) begin
        c_f[k] <= c_f[k-1];
        c_e[k] <= c_e[k-1];
        c_dg[k] <= c_dg[k-1];
      end

      t_dg[1] <= c_dg[LAT] | zc;
      t_s[1] <= nc;
      t_f[1] <= c_f[LAT];
      t_e[1] <= c_e[LAT];
      for (int k = 2; k <= 6; k++) begin
        t_dg[k] <= t_dg[k-1];
        t_s[k] <= t_s[k-1];
        t_f[k] <= t_f[k-1];
      end
      for (int k = 2; k <= 3; k++) t_e[k] <= t_e[k-1];
      t_u[3] <= u_n;
      for (int k = 4; k <= 6; k++) t_u[k] <= t_u[k-1];

      t1_p[0] <= PW'($signed(nc[1])) * PW'($signed(c_f[LAT][2]));
      t1_p[1] <= PW'($signed(nc[2])) * PW'($signed(c_f[LAT][1]));
      t1_p[2] <= PW'($signed(nc[2])) * PW'($signed(c_f[LAT][0]));
      t1_p[3] <= PW'($signed(nc[0])) * PW'($signed(c_f[LAT][2]));
      t1_p[4] <= PW'($signed(nc[0])) * PW'($signed(c_f[LAT][1]));
      t1_p[5] <= PW'($signed(nc[1])) * PW'($signed(c_f[LAT][0]));
      for (int i = 0; i < 3; i++) begin
        t2_d[i] <= CW'(t1_p[2*i]) - CW'(t1_p[2*i+1]);
      end

      for (int i = 0; i < 3; i++) begin
        t4_p[0][i] <= DPW'($signed(t_s[3][i])) * DPW'($signed(t_e[3][i]));
        t4_p[1][i] <= DPW'($signed(t_u[3][i])) * DPW'($signed(t_e[3][i]));
        t4_p[2][i] <= DPW'($signed(t_f[3][i])) * DPW'($signed(t_e[3][i]));
      end
      for (int r = 0; r < 3; r++) begin
        t5_sum[r] <= DSW'(t4_p[r][0]) + DSW'(t4_p[r][1]) + DSW'(t4_p[r][2]);
        t6_r[r] <= r_n[r];
      end
      t6_sg <= sg_n;

      ob_dg <= t_dg[6];
      ob_s <= t_s[6];
      ob_u <= t_u[6];
      ob_f <= t_f[6];
      ob_t <= col3_n;
    end
  end

  always_comb begin
    col = '0;
    unique case (ob_row)
      ROW_SIDE: begin
        for (int i = 0; i < 3; i++) col[i] = 32'($signed(ob_s[i]));
        col[3] = ob_t[0];
      end
      ROW_UP: begin
        for (int i = 0; i < 3; i++) col[i] = 32'($signed(ob_u[i]));
        col[3] = ob_t[1];
      end
      ROW_FWD: begin
        for (int i = 0; i < 3; i++) col[i] = -32'($signed(ob_f[i]));
        col[3] = ob_t[2];
      end
      ROW_CONST: begin
        col[3] = ONE;
      end
      default: begin
        col = '0;
      end
    endcase
    if (ob_dg && ob_row != ROW_CONST) col = '0;
  end

  assign rsp.valid = ob_v;
  assign rsp.data.row_index = ob_row;
  assign rsp.data.col0 = col[0];
  assign rsp.data.col1 = col[1];
  assign rsp.data.col2 = col[2];
  assign rsp.data.col3 = col[3];
  assign rsp.data.degenerate = ob_dg;
  assign rsp.data.last_row = (ob_row == ROW_CONST);

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    take && ob_row != ROW_CONST |=> ob_v && ob_row == lav_row_t'($past(ob_row) + 2'd1))
    else $error("row sequence broken");

  a_first_row: assert property (@(posedge clk) disable iff (rst)
    $rose(ob_v) |-> ob_row == ROW_SIDE)
    else $error("item does not start at side row");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(t_v[6]) && $stable(p_v) && $stable(x2_v))
    else $error("pipeline moved during stall");

  a_norm_align: assert property (@(posedge clk) disable iff (rst)
    va == vb)
    else $error("forward and up normalizers out of step");

endmodule
